>>> rtl/flms_pkg.sv
// Package: constants, register codes and queue entry type for the line substitute block.
package flms_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int LINE_LIMIT  = 4095;

  localparam int LEN_W      = 4;
  localparam int BYTES_W    = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int LINE_CNT_W = $clog2(LINE_LIMIT + 1);
  localparam int LIST_LEN   = (MAX_PATTERN + 1 > MAX_REPLACE) ? MAX_PATTERN + 1 : MAX_REPLACE;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 8'd0,
    REG_PATTERN_LENGTH = 8'd1,
    REG_REPLACE_BYTES  = 8'd2,
    REG_REPLACE_LENGTH = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LIST_LEN-1:0][7:0] bytes;
    logic [LEN_W-1:0]         n;
  } job_t;

endpackage

>>> rtl/flms_in_if.sv
// Interface: input byte channel.
interface flms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source(output valid, output in_byte, output end_of_input, input ready);
  modport sink(input valid, input in_byte, input end_of_input, output ready);
endinterface

>>> rtl/flms_out_if.sv
// Interface: result byte channel.
interface flms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source(output valid, output out_byte, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/flms_cfg_if.sv
// Interface: configuration write channel.
interface flms_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] wdata;

  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

>>> rtl/flms_front.sv
// Front end: configuration registers, pending window, match compare and job build.
module flms_front (
  input  logic          clk,
  input  logic          rst_n,
  flms_in_if.sink       in_ch,
  flms_cfg_if.sink      cfg_ch,
  output logic          push_valid,
  output flms_pkg::job_t push_job,
  input  logic          push_ready
);
  import flms_pkg::*;

  logic [BYTES_W-1:0]    pattern_r;
  logic [LEN_W-1:0]      pattern_len_r;
  logic [BYTES_W-1:0]    replace_r;
  logic [LEN_W-1:0]      replace_len_r;

  logic [7:0]            win_r [MAX_PATTERN];
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;
  logic                  replaced_r, replaced_nxt;
  logic [LINE_CNT_W-1:0] line_cnt_r, line_cnt_nxt;

  logic [7:0]            win_pad [LIST_LEN];
  logic [7:0]            ext [LIST_LEN];
  logic [LIST_LEN-1:0][7:0] rep_list;
  logic [LIST_LEN-1:0][7:0] ext_list;
  logic [LEN_W-1:0]      plen, rlen;
  logic                  match, full, line_end, in_acc, win_wr, win_shift;
  logic [LINE_CNT_W-1:0] line_cnt_inc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    plen = pattern_len_r;
    if (pattern_len_r == '0) plen = LEN_W'(1);
    else if (pattern_len_r > LEN_W'(MAX_PATTERN)) plen = LEN_W'(MAX_PATTERN);
    rlen = (replace_len_r > LEN_W'(MAX_REPLACE)) ? LEN_W'(MAX_REPLACE) : replace_len_r;

    for (int i = 0; i < MAX_PATTERN; i++) win_pad[i] = win_r[i];
    for (int i = MAX_PATTERN; i < LIST_LEN; i++) win_pad[i] = '0;
    for (int i = 0; i < LIST_LEN; i++) begin
      ext[i]      = (LEN_W'(i) < cnt_r) ? win_pad[i] : in_ch.in_byte;
      ext_list[i] = ext[i];
    end
    rep_list = '0;
    for (int i = 0; i < MAX_REPLACE; i++) rep_list[i] = replace_r[8*i +: 8];

    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < plen) && (ext[i] != pattern_r[8*i +: 8])) match = 1'b0;
    end
    full = (cnt_r + LEN_W'(1)) == plen;

    line_cnt_inc = line_cnt_r + LINE_CNT_W'(1);
    line_end = (in_ch.in_byte == NEWLINE) || in_ch.end_of_input ||
               (line_cnt_inc >= LINE_CNT_W'(LINE_LIMIT));

    push_job.bytes = ext_list;
    push_job.n     = '0;
    cnt_nxt        = cnt_r;
    replaced_nxt   = replaced_r;
    win_wr         = 1'b0;
    win_shift      = 1'b0;

    priority if (replaced_r) begin
      push_job.n = LEN_W'(1);
    end else if (cnt_r >= plen) begin
      push_job.n   = cnt_r + LEN_W'(1);
      cnt_nxt      = '0;
      replaced_nxt = 1'b1;
    end else if (full && match) begin
      push_job.bytes = rep_list;
      push_job.n     = rlen;
      cnt_nxt        = '0;
      replaced_nxt   = 1'b1;
    end else if (full) begin
      push_job.n = line_end ? plen : LEN_W'(1);
      cnt_nxt    = plen - LEN_W'(1);
      win_wr     = 1'b1;
      win_shift  = 1'b1;
    end else begin
      push_job.n = line_end ? cnt_r + LEN_W'(1) : '0;
      cnt_nxt    = cnt_r + LEN_W'(1);
      win_wr     = 1'b1;
    end

    line_cnt_nxt = line_cnt_inc;
    if (line_end) begin
      cnt_nxt      = '0;
      replaced_nxt = 1'b0;
      line_cnt_nxt = '0;
    end

    push_valid = in_acc && (push_job.n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r     <= '0;
      pattern_len_r <= LEN_W'(1);
      replace_r     <= '0;
      replace_len_r <= '0;
      cnt_r         <= '0;
      replaced_r    <= 1'b0;
      line_cnt_r    <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_PATTERN_BYTES:  pattern_r     <= cfg_ch.wdata;
          REG_PATTERN_LENGTH: pattern_len_r <= cfg_ch.wdata[LEN_W-1:0];
          REG_REPLACE_BYTES:  replace_r     <= cfg_ch.wdata;
          REG_REPLACE_LENGTH: replace_len_r <= cfg_ch.wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_r      <= cnt_nxt;
        replaced_r <= replaced_nxt;
        line_cnt_r <= line_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && win_wr) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= win_shift ? ext[i+1] : ext[i];
      end
    end
  end

endmodule

>>> rtl/flms_queue.sv
// Job queue between the front end and the output serializer.
module flms_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  flms_pkg::job_t push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output flms_pkg::job_t pop_job,
  input  logic           pop_ready
);
  import flms_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push, pop;

  assign push_ready = count_r != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop) count_r <= count_r + (QPTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

endmodule

>>> rtl/flms_back.sv
// Back end: serialize each queued job into output byte transfers.
module flms_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  input  flms_pkg::job_t pop_job,
  output logic           pop_ready,
  flms_out_if.source     out_ch
);
  import flms_pkg::*;

  logic [LEN_W-1:0] idx_r;
  logic             last, xfer;

  assign last               = idx_r == (pop_job.n - LEN_W'(1));
  assign out_ch.valid       = pop_valid;
  assign out_ch.out_byte    = pop_job.bytes[idx_r];
  assign out_ch.last_of_run = last;
  assign xfer               = out_ch.valid && out_ch.ready;
  assign pop_ready          = xfer && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (xfer) begin
      idx_r <= last ? '0 : idx_r + LEN_W'(1);
    end
  end

endmodule

>>> rtl/first_match_line_substitute.sv
// Top level: first-match-per-line substitution over a byte stream.
// The block takes one text byte per cycle and replaces the leftmost match of the
// pattern in each line; the front end compares the whole window combinationally
// and places the output bytes of that input, up to eight, into a four-entry job
// queue, and the back end sends them one byte per cycle while the output is ready,
// so an input that causes n results takes n output transfers. Input stalls only
// while the queue is full; an input with zero or one result sustains one byte per
// cycle while the output is ready. Results are registered in the job queue first.
module first_match_line_substitute (
  input  logic       clk,
  input  logic       rst_n,
  flms_in_if.sink    in_ch,
  flms_out_if.source out_ch,
  flms_cfg_if.sink   cfg_ch
);
  import flms_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  flms_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  flms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  flms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_job_len: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (push_job.n != '0) && (push_job.n <= LEN_W'(LIST_LEN)))
    else $error("job length out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("push into full queue");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("output run broken before last byte");
`endif

endmodule

>>> verif/flms_checker.sv
// Checker for the line substitute block: predicts output bytes per input transfer and compares.
module flms_checker
  import flms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  flms_in_if          in_mon,
  flms_out_if         out_mon,
  flms_cfg_if         cfg_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       tail;
  } out_beat_t;

  out_beat_t             expected_bytes[$];
  logic [7:0]            held_bytes[MAX_PATTERN];
  int                    held_cnt;
  bit                    line_done;
  int                    line_len;
  logic [BYTES_W-1:0]    pat_bytes;
  logic [BYTES_W-1:0]    rep_bytes;
  logic [LEN_W-1:0]      pat_len;
  logic [LEN_W-1:0]      rep_len;
  int unsigned           fail_cnt = 0;

  function automatic void substitute_byte(input logic [7:0] b, input logic eoi);
    out_beat_t run[$];
    int        plen;
    int        rlen;
    bit        hit;
    plen = pat_len;
    rlen = rep_len;
    if (plen < 1) plen = 1;
    if (plen > MAX_PATTERN) plen = MAX_PATTERN;
    if (rlen > MAX_REPLACE) rlen = MAX_REPLACE;

    if (line_done) begin
      run.push_back('{b, 1'b0});
    end else if (held_cnt >= plen) begin
      for (int i = 0; i < held_cnt && i < MAX_PATTERN; i++) run.push_back('{held_bytes[i], 1'b0});
      held_cnt = 0;
      run.push_back('{b, 1'b0});
      line_done = 1'b1;
    end else begin
      held_bytes[held_cnt] = b;
      held_cnt++;
      if (held_cnt == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++) begin
          if (held_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < rlen; i++) run.push_back('{rep_bytes[8*i +: 8], 1'b0});
          held_cnt = 0;
          line_done = 1'b1;
        end else begin
          run.push_back('{held_bytes[0], 1'b0});
          for (int i = 1; i < plen; i++) held_bytes[i-1] = held_bytes[i];
          held_cnt--;
        end
      end
    end

    line_len++;
    if (b == NEWLINE || eoi || line_len >= LINE_LIMIT) begin
      for (int i = 0; i < held_cnt && i < MAX_PATTERN; i++) run.push_back('{held_bytes[i], 1'b0});
      held_cnt  = 0;
      line_done = 1'b0;
      line_len  = 0;
    end

    if (run.size() > 0) run[run.size()-1].tail = 1'b1;
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endfunction

  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      foreach (held_bytes[i]) held_bytes[i] = '0;
      held_cnt  = 0;
      line_done = 1'b0;
      line_len  = 0;
      pat_bytes = '0;
      pat_len   = LEN_W'(1);
      rep_bytes = '0;
      rep_len   = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.out_byte, out_mon.last_of_run};
        if (expected_bytes.size() == 0) begin
          if (fail_cnt < 10)
            $display("mismatch: unexpected byte %02h last %0b", got.ch, got.tail);
          fail_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.ch !== want.ch || got.tail !== want.tail) begin
            if (fail_cnt < 10)
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.ch, want.tail, got.ch, got.tail);
            fail_cnt++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_PATTERN_BYTES:  pat_bytes = cfg_mon.wdata;
          REG_PATTERN_LENGTH: pat_len   = cfg_mon.wdata[LEN_W-1:0];
          REG_REPLACE_BYTES:  rep_bytes = cfg_mon.wdata;
          REG_REPLACE_LENGTH: rep_len   = cfg_mon.wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        substitute_byte(in_mon.in_byte, in_mon.end_of_input);
    end
    mismatches  <= fail_cnt;
    outstanding <= expected_bytes.size();
  end

endmodule

>>> verif/tb_top.sv
// Testbench top: drives text bytes and register writes into the line substitute block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import flms_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned outstanding;
  int          send_idle;
  int          recv_stall;
  int unsigned bytes_sent;
  logic [63:0] cur_pat;
  int          cur_plen;
  logic [7:0]  letters[3];

  flms_in_if  in_ch();
  flms_out_if out_ch();
  flms_cfg_if cfg_ch();

  first_match_line_substitute u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  flms_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic int eff_len(input int v);
    if (v < 1) return 1;
    if (v > MAX_PATTERN) return MAX_PATTERN;
    return v;
  endfunction

  task automatic set_mode(input int m);
    case (m)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 85; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 85; end
      default: begin send_idle = 8; recv_stall = 8; end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // hold off until every expected byte has been seen, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [63:0] pb, input int pl,
                              input logic [63:0] rb, input int rl);
    cfg_write(REG_PATTERN_BYTES, pb);
    cfg_write(REG_PATTERN_LENGTH, 64'(pl));
    cfg_write(REG_REPLACE_BYTES, rb);
    cfg_write(REG_REPLACE_LENGTH, 64'(rl));
    cur_pat  = pb;
    cur_plen = eff_len(pl);
  endtask

  task automatic send_line(input bit noisy);
    int         n;
    int         r;
    int         part;
    logic [7:0] b;
    n = $urandom_range(24);
    if (noisy) begin
      for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
    end else begin
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(99);
        if (r < 15) begin
          part = ($urandom_range(3) == 0) ? $urandom_range(1, cur_plen) : cur_plen;
          for (int j = 0; j < part; j++) send_byte(cur_pat[8*j +: 8], 1'b0);
        end else if (r < 85) begin
          send_byte(letters[$urandom_range(2)], 1'b0);
        end else begin
          send_byte(8'($urandom_range(255)), 1'b0);
        end
      end
      r = $urandom_range(99);
      if (r < 85) begin
        send_byte(NEWLINE, 1'b0);
      end else if (r < 95) begin
        b = letters[$urandom_range(2)];
        send_byte(b, 1'b1);
      end
    end
  endtask

  initial begin
    int          pl;
    int          rl;
    int unsigned target;
    logic [63:0] pat;
    logic [63:0] data;
    logic [7:0]  b;

    in_ch.valid        = 1'b0;
    in_ch.in_byte      = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.wdata       = '0;
    rst_n              = 1'b0;
    send_idle          = 0;
    recv_stall         = 0;
    bytes_sent         = 0;
    cur_pat            = '0;
    cur_plen           = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: single zero byte pattern, empty replacement
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(NEWLINE, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();
    cfg_write(8'd4, {$urandom, $urandom});
    cfg_write(8'hFF, {$urandom, $urandom});

    apply_config(64'h636261, 3, 64'h5A, 1);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(NEWLINE, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    // shorten the pattern while two bytes are held
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    drain();
    cfg_write(REG_PATTERN_BYTES, 64'h71);
    cfg_write(REG_PATTERN_LENGTH, 64'd1);
    cur_pat  = 64'h71;
    cur_plen = 1;
    send_byte(8'h63, 1'b0);
    send_byte(NEWLINE, 1'b0);
    drain();

    apply_config(64'h8877665544332211, 15, 64'h0123456789ABCDEF, 15);
    for (int k = 0; k < 8; k++) send_byte(cur_pat[8*k +: 8], (k == 7));
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin pl = 1;  rl = 0;  end
        1: begin pl = 8;  rl = 8;  end
        2: begin pl = 0;  rl = 15; end
        3: begin pl = 15; rl = 1;  end
        default: begin pl = $urandom_range(15); rl = $urandom_range(15); end
      endcase
      foreach (letters[k]) letters[k] = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) letters[2] = $urandom_range(1) ? NEWLINE : 8'h00;
      for (int k = 0; k < 8; k++) pat[8*k +: 8] = letters[$urandom_range(2)];
      set_mode(ph % 4);
      apply_config(pat, pl, {$urandom, $urandom}, rl);
      target = bytes_sent + 32;
      while (bytes_sent < target) begin
        send_line($urandom_range(9) == 0);
        if ($urandom_range(11) == 0) begin
          drain();
          data      = {$urandom, $urandom};
          data[3:0] = 4'($urandom_range(15));
          cfg_write(REG_PATTERN_LENGTH, data);
          cur_plen = eff_len(int'(data[3:0]));
          if ($urandom_range(1) == 0) begin
            for (int k = 0; k < 8; k++) pat[8*k +: 8] = letters[$urandom_range(2)];
            cfg_write(REG_PATTERN_BYTES, pat);
            cur_pat = pat;
          end
        end
      end
      drain();
    end

    // one line longer than the line limit, no newline inside
    set_mode(0);
    apply_config({$urandom, $urandom}, 8, {$urandom, $urandom}, 8);
    for (int k = 0; k < LINE_LIMIT + 5; k++) begin
      b = 8'($urandom_range(255));
      if (b == NEWLINE) b = 8'h0B;
      send_byte(b, 1'b0);
    end
    send_byte(NEWLINE, 1'b0);
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
